// ===== rtl/observation_session_tracker_assert.svh =====
// ----------------------------------------------------------------------------
// observation session tracker assertion macros
// concurrent assertion wrappers, compiled out when ASSERT_OFF is defined
// ----------------------------------------------------------------------------
`ifndef OBSERVATION_SESSION_TRACKER_ASSERT_SVH
`define OBSERVATION_SESSION_TRACKER_ASSERT_SVH

`ifndef ASSERT_OFF

`define OST_ASSERT(lbl, clk, rstn, prop, msg) \
    lbl: assert property (@(posedge clk) disable iff (!rstn) prop) else $error(msg);

`define OST_ASSERT_NEVER(lbl, clk, rstn, expr, msg) \
    lbl: assert property (@(posedge clk) disable iff (!rstn) !(expr)) else $error(msg);

`else

`define OST_ASSERT(lbl, clk, rstn, prop, msg)

`define OST_ASSERT_NEVER(lbl, clk, rstn, expr, msg)

`endif

`endif

// ===== rtl/obst_pkg.sv =====
// ----------------------------------------------------------------------------
// obst_pkg
// shared types and constants of the observation session tracker
// ----------------------------------------------------------------------------
package obst_pkg;

    localparam int TABLE_ENTRIES_DEF = 16;
    localparam int KEY_W             = 32;
    localparam int TIME_W            = 32;
    localparam int SEQ_W             = 32;
    localparam int ENTRY_IDX_W       = 4;
    localparam int S_TDATA_W         = 96;
    localparam int M_TDATA_W         = 72;
    localparam int M_TDATA_USED_W    = SEQ_W + TIME_W + ENTRY_IDX_W;

    localparam logic [TIME_W-1:0] GAP_RESET = TIME_W'(1000);

    typedef enum logic [1:0] {
        ST_IDLE,
        ST_SCAN,
        ST_WRITE
    } state_t;

    typedef struct packed {
        logic [KEY_W-1:0]  adv_key;
        logic [KEY_W-1:0]  st_key;
        logic [TIME_W-1:0] last_seen;
        logic [SEQ_W-1:0]  seq;
        logic [TIME_W-1:0] start;
    } slot_row_t;

endpackage

// ===== rtl/observation_session_tracker.sv =====
// ----------------------------------------------------------------------------
// observation_session_tracker
// groups sightings (advertiser key, state key, time) into observations
// ----------------------------------------------------------------------------
// s_ channel: one sighting per transfer, tdata = advertiser key, state key,
// time in ms. m_ channel: one result per sighting, tdata = observation
// sequence, observation start time, entry index; tuser = new-observation flag.
// cfg_wr_en/cfg_wr_data write the inactivity gap; a nonzero write also clears
// the table and the sequence counter, a zero write is dropped.
// The table rows sit in one synchronous memory read once per cycle during a
// linear scan; valid bits are flip-flops. The scan of a sighting ends at the
// first matching entry or after the last entry, so it is shorter when a
// matching entry comes early in the scan. The result is written into the
// output register at the write-back, which waits until the output register
// is free. The memory read-modify-write of one sighting ends before the next
// scan starts, so accesses never overlap.
// Reset clears all valid bits, the sequence counter, the gap (to 1000 ms) and
// the output valid flag. When m_tready is low the result waits in the output
// register; the next sighting is taken and scanned but holds in its write
// cycle until the output register is free.
// ----------------------------------------------------------------------------
`include "observation_session_tracker_assert.svh"

module observation_session_tracker #(
    parameter int TABLE_ENTRIES = obst_pkg::TABLE_ENTRIES_DEF
) (
    input  logic                           aclk,
    input  logic                           aresetn,
    input  logic                           cfg_wr_en,
    input  logic [obst_pkg::TIME_W-1:0]    cfg_wr_data,
    input  logic                           s_tvalid,
    output logic                           s_tready,
    // advertiser_key, state_key, now_ms
    input  logic [obst_pkg::S_TDATA_W-1:0] s_tdata,
    output logic                           m_tvalid,
    input  logic                           m_tready,
    // observation_seq, observation_start_ms, entry_index, zero pad
    output logic [obst_pkg::M_TDATA_W-1:0] m_tdata,
    // is_new
    output logic                           m_tuser
);

    import obst_pkg::*;

    localparam int IDX_W = (TABLE_ENTRIES > 1) ? $clog2(TABLE_ENTRIES) : 1;
    localparam logic [IDX_W-1:0] LAST_IDX = IDX_W'(TABLE_ENTRIES - 1);

    state_t state_reg, state_next;

    slot_row_t slot_mem [TABLE_ENTRIES];
    slot_row_t rd_row_reg;

    logic [TABLE_ENTRIES-1:0] slot_valid_reg;
    logic [SEQ_W-1:0]         seq_counter_reg;
    logic [TIME_W-1:0]        gap_reg;

    logic [KEY_W-1:0]  adv_reg;
    logic [KEY_W-1:0]  st_reg;
    logic [TIME_W-1:0] now_reg;

    logic [IDX_W-1:0] rd_addr_reg;
    logic [IDX_W-1:0] chk_idx_reg;
    logic             chk_vld_reg;

    logic              match_found_reg;
    logic [IDX_W-1:0]  match_idx_reg;
    logic              cont_reg;
    logic [SEQ_W-1:0]  match_seq_reg;
    logic [TIME_W-1:0] match_start_reg;
    logic              free_found_reg;
    logic [IDX_W-1:0]  free_idx_reg;
    logic              oldest_found_reg;
    logic [IDX_W-1:0]  oldest_idx_reg;
    logic [TIME_W-1:0] oldest_age_reg;

    logic                 m_tvalid_reg;
    logic [M_TDATA_W-1:0] m_tdata_reg;
    logic                 m_tuser_reg;

    logic              s_accept;
    logic              out_free;
    logic              m_load;
    logic              rd_en;
    logic              chk_row_valid;
    logic              hit;
    logic              scan_done;
    logic [TIME_W-1:0] age;
    logic              new_obs;
    logic [IDX_W-1:0]  pick;
    logic [SEQ_W-1:0]  out_seq;
    logic [TIME_W-1:0] out_start;
    slot_row_t         wr_row;

    assign out_free      = !m_tvalid_reg || m_tready;
    assign s_accept      = s_tvalid && s_tready;
    assign chk_row_valid = slot_valid_reg[chk_idx_reg];
    assign hit           = chk_vld_reg && chk_row_valid &&
                           (rd_row_reg.adv_key == adv_reg) && (rd_row_reg.st_key == st_reg);
    assign scan_done     = chk_vld_reg && (hit || (chk_idx_reg == LAST_IDX));
    assign age           = now_reg - rd_row_reg.last_seen;

    // next state
    always_comb begin
        state_next = state_reg;
        unique case (state_reg)
            ST_IDLE: begin
                if (s_tvalid) begin
                    state_next = ST_SCAN;
                end
            end
            ST_SCAN: begin
                if (scan_done) begin
                    state_next = ST_WRITE;
                end
            end
            ST_WRITE: begin
                if (out_free) begin
                    state_next = ST_IDLE;
                end
            end
            default: state_next = ST_IDLE;
        endcase
    end

    // state outputs
    always_comb begin
        s_tready = 1'b0;
        rd_en    = 1'b0;
        m_load   = 1'b0;
        unique case (state_reg)
            ST_IDLE:  s_tready = 1'b1;
            ST_SCAN:  rd_en    = 1'b1;
            ST_WRITE: m_load   = out_free;
            default:  s_tready = 1'b0;
        endcase
    end

    // entry choice for the write-back
    always_comb begin
        priority if (match_found_reg) begin
            pick = match_idx_reg;
        end else if (free_found_reg) begin
            pick = free_idx_reg;
        end else if (oldest_found_reg) begin
            pick = oldest_idx_reg;
        end else begin
            pick = '0;
        end
        new_obs   = !match_found_reg || !cont_reg;
        out_seq   = new_obs ? (seq_counter_reg + SEQ_W'(1)) : match_seq_reg;
        out_start = new_obs ? now_reg : match_start_reg;
        wr_row.adv_key   = adv_reg;
        wr_row.st_key    = st_reg;
        wr_row.last_seen = now_reg;
        wr_row.seq       = out_seq;
        wr_row.start     = out_start;
    end

    // table memory
    always_ff @(posedge aclk) begin
        if (m_load) begin
            slot_mem[pick] <= wr_row;
        end
        if (rd_en) begin
            rd_row_reg <= slot_mem[rd_addr_reg];
        end
    end

    // control state
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            state_reg        <= ST_IDLE;
            slot_valid_reg   <= '0;
            seq_counter_reg  <= '0;
            gap_reg          <= GAP_RESET;
            chk_vld_reg      <= 1'b0;
            match_found_reg  <= 1'b0;
            free_found_reg   <= 1'b0;
            oldest_found_reg <= 1'b0;
            m_tvalid_reg     <= 1'b0;
        end else begin
            state_reg   <= state_next;
            chk_vld_reg <= (state_reg == ST_SCAN) && !scan_done;
            if (s_accept) begin
                match_found_reg  <= 1'b0;
                free_found_reg   <= 1'b0;
                oldest_found_reg <= 1'b0;
            end
            if (chk_vld_reg && (state_reg == ST_SCAN)) begin
                if (hit) begin
                    match_found_reg <= 1'b1;
                end else if (chk_row_valid) begin
                    if (!oldest_found_reg || (age > oldest_age_reg)) begin
                        oldest_found_reg <= 1'b1;
                    end
                end else if (!free_found_reg) begin
                    free_found_reg <= 1'b1;
                end
            end
            if (cfg_wr_en && (cfg_wr_data != '0)) begin
                gap_reg         <= cfg_wr_data;
                slot_valid_reg  <= '0;
                seq_counter_reg <= '0;
            end else if (m_load) begin
                slot_valid_reg[pick] <= 1'b1;
                if (new_obs) begin
                    seq_counter_reg <= out_seq;
                end
            end
            if (m_load) begin
                m_tvalid_reg <= 1'b1;
            end else if (m_tready) begin
                m_tvalid_reg <= 1'b0;
            end
        end
    end

    // scan datapath
    always_ff @(posedge aclk) begin
        if (s_accept) begin
            adv_reg     <= s_tdata[KEY_W-1:0];
            st_reg      <= s_tdata[2*KEY_W-1:KEY_W];
            now_reg     <= s_tdata[2*KEY_W+TIME_W-1:2*KEY_W];
            rd_addr_reg <= '0;
        end else if (rd_en && (rd_addr_reg != LAST_IDX)) begin
            rd_addr_reg <= rd_addr_reg + IDX_W'(1);
        end
        chk_idx_reg <= rd_addr_reg;
        if (chk_vld_reg && (state_reg == ST_SCAN)) begin
            if (hit) begin
                match_idx_reg   <= chk_idx_reg;
                cont_reg        <= age < gap_reg;
                match_seq_reg   <= rd_row_reg.seq;
                match_start_reg <= rd_row_reg.start;
            end else if (chk_row_valid) begin
                if (!oldest_found_reg || (age > oldest_age_reg)) begin
                    oldest_idx_reg <= chk_idx_reg;
                    oldest_age_reg <= age;
                end
            end else if (!free_found_reg) begin
                free_idx_reg <= chk_idx_reg;
            end
        end
        if (m_load) begin
            m_tdata_reg <= M_TDATA_W'({ENTRY_IDX_W'(pick), out_start, out_seq});
            m_tuser_reg <= new_obs;
        end
    end

    assign m_tvalid = m_tvalid_reg;
    assign m_tdata  = m_tdata_reg;
    assign m_tuser  = m_tuser_reg;

    `OST_ASSERT(a_accept_starts_scan, aclk, aresetn, s_accept |=> (state_reg == ST_SCAN), "transfer accepted without starting a scan")
    `OST_ASSERT(a_seq_only_on_write, aclk, aresetn, ((state_reg != ST_WRITE) && !cfg_wr_en) |=> $stable(seq_counter_reg), "sequence counter moved outside a write-back")
    `OST_ASSERT(a_continue_needs_match, aclk, aresetn, (m_load && !new_obs) |-> match_found_reg, "continued observation without a matching entry")
    `OST_ASSERT_NEVER(a_chk_idx_range, aclk, aresetn, chk_vld_reg && (chk_idx_reg > LAST_IDX), "scan index beyond the table")

endmodule
